// ----- hw/rtl/vbrp_pkg.sv -----
// Package for the VCP brightness reply parser: request and result types,
// status codes and the frame constants. Depends on nothing.
`default_nettype none

package vbrp_pkg;

  localparam int unsigned FrameLen   = 11;
  localparam int unsigned CaptureLen = 10;

  localparam logic [3:0] COUNT_MAX      = 4'd15;
  localparam logic [7:0] SRC_ADDR       = 8'h6e;
  localparam logic [7:0] NULL_HDR       = 8'h80;
  localparam logic [7:0] REPLY_HDR      = 8'h88;
  localparam logic [7:0] CSUM_SEED      = 8'h50;
  localparam logic [7:0] GET_REPLY_OP   = 8'h02;
  localparam logic [7:0] VCP_BRIGHT     = 8'h10;
  localparam logic [7:0] RC_UNSUPPORTED = 8'h01;

  typedef enum logic [3:0] {
    ST_OK             = 4'd0,
    ST_LENGTH         = 4'd1,
    ST_SOURCE         = 4'd2,
    ST_NULL           = 4'd3,
    ST_HEADER         = 4'd4,
    ST_CHECKSUM       = 4'd5,
    ST_NOT_QUERY      = 4'd6,
    ST_UNSUPPORTED    = 4'd7,
    ST_UNKNOWN_CODE   = 4'd8,
    ST_NOT_CONTINUOUS = 4'd9,
    ST_INCONSISTENT   = 4'd10
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] current_level;
    logic [15:0] maximum_level;
  } result_t;

  typedef logic [CaptureLen-1:0][7:0] capture_t;

endpackage

`default_nettype wire

// ----- hw/rtl/vbrp_judge.sv -----
// Frame checks of the VCP brightness reply parser: turns the byte count,
// final checksum and captured bytes into a result. Depends on vbrp_pkg.
`default_nettype none

module vbrp_judge (
  input  wire logic [3:0]        total,
  input  wire logic [7:0]        csum,
  input  wire vbrp_pkg::capture_t cap,
  output vbrp_pkg::result_t      result
);

  logic [15:0] mx;
  logic [15:0] cu;

  assign mx = {cap[6], cap[7]};
  assign cu = {cap[8], cap[9]};

  // The first failing check sets the status, in priority order.
  always_comb begin
    result.current_level = '0;
    result.maximum_level = '0;
    if (total != 4'(vbrp_pkg::FrameLen)) begin
      result.status = vbrp_pkg::ST_LENGTH;
    end else if (cap[0] != vbrp_pkg::SRC_ADDR) begin
      result.status = vbrp_pkg::ST_SOURCE;
    end else if (cap[1] == vbrp_pkg::NULL_HDR) begin
      result.status = vbrp_pkg::ST_NULL;
    end else if (cap[1] != vbrp_pkg::REPLY_HDR) begin
      result.status = vbrp_pkg::ST_HEADER;
    end else if (csum != 8'h00) begin
      result.status = vbrp_pkg::ST_CHECKSUM;
    end else if (cap[2] != vbrp_pkg::GET_REPLY_OP || cap[4] != vbrp_pkg::VCP_BRIGHT) begin
      result.status = vbrp_pkg::ST_NOT_QUERY;
    end else if (cap[3] == vbrp_pkg::RC_UNSUPPORTED) begin
      result.status = vbrp_pkg::ST_UNSUPPORTED;
    end else if (cap[3] != 8'h00) begin
      result.status = vbrp_pkg::ST_UNKNOWN_CODE;
    end else if (cap[5] != 8'h00) begin
      result.status = vbrp_pkg::ST_NOT_CONTINUOUS;
    end else if (mx == 16'h0000 || cu > mx) begin
      result.status = vbrp_pkg::ST_INCONSISTENT;
    end else begin
      result.status        = vbrp_pkg::ST_OK;
      result.current_level = cu;
      result.maximum_level = mx;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/vcp_brightness_reply_parser_core.sv -----
// VCP brightness reply parser, top level. Depends on vbrp_pkg and vbrp_judge.
// Throughput: one frame byte per cycle, back to back, across frame boundaries,
// unless a final byte waits on a stalled, full result register. A final byte
// passes the input register, then the result register; the stall path is only
// the output register's stall. Synchronous reset clears both valid flags, the
// byte count and the running checksum; captured bytes need no reset.
`default_nettype none

module vcp_brightness_reply_parser_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                frame_valid,
  output logic                     frame_stall,
  input  wire vbrp_pkg::byte_req_t frame_data,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output vbrp_pkg::result_t        result_data
);

  // Input register: holds one accepted byte request.
  logic                in_v;
  vbrp_pkg::byte_req_t in_req;

  // Frame state.
  logic [3:0]         byte_count;
  logic [7:0]         xor_acc;
  vbrp_pkg::capture_t cap;

  logic               out_free;
  logic               advance;
  logic [3:0]         total;
  logic [7:0]         csum;
  vbrp_pkg::capture_t cap_next;
  vbrp_pkg::result_t  judged;

  // The result register is free when it is empty or being taken this cycle.
  assign out_free = !result_valid || !result_stall;

  // A byte that is not final always moves on; a final one needs the result
  // register to be free.
  assign advance     = in_v && (!in_req.last_byte || out_free);
  assign frame_stall = in_v && !advance;

  // Count and checksum including the byte in the input register.
  assign total = (byte_count == vbrp_pkg::COUNT_MAX) ? byte_count : byte_count + 4'd1;
  assign csum  = xor_acc ^ in_req.data_byte;

  // Only the first ten bytes are captured. The final byte of a good frame is
  // byte eleven, so the checks see every captured byte in its register.
  always_comb begin
    cap_next = cap;
    if (byte_count < 4'(vbrp_pkg::CaptureLen)) begin
      cap_next[byte_count] = in_req.data_byte;
    end
  end

  vbrp_judge u_judge (
    .total  (total),
    .csum   (csum),
    .cap    (cap),
    .result (judged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (!frame_stall) begin
      in_v <= frame_valid;
    end
    if (!frame_stall && frame_valid) begin
      in_req <= frame_data;
    end
  end

  // Frame state moves with each byte; the final byte returns it to its start.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      xor_acc    <= vbrp_pkg::CSUM_SEED;
    end else if (advance) begin
      if (in_req.last_byte) begin
        byte_count <= '0;
        xor_acc    <= vbrp_pkg::CSUM_SEED;
      end else begin
        byte_count <= total;
        xor_acc    <= csum;
      end
    end
    if (advance && !in_req.last_byte) begin
      cap <= cap_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && in_req.last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance && in_req.last_byte) begin
      result_data <= judged;
    end
  end

  // A failing status carries no levels.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.status != vbrp_pkg::ST_OK |->
      result_data.current_level == 16'h0000 && result_data.maximum_level == 16'h0000)
    else $error("failing result carries nonzero levels");

  // A good result is always consistent.
  a_ok_consistent: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.status == vbrp_pkg::ST_OK |->
      result_data.maximum_level != 16'h0000 &&
      result_data.current_level <= result_data.maximum_level)
    else $error("good result with inconsistent levels");

  // The final byte clears the frame state for the next frame.
  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    advance && in_req.last_byte |=>
      byte_count == 4'd0 && xor_acc == vbrp_pkg::CSUM_SEED && result_valid)
    else $error("frame state not cleared after final byte");

  // Input stalls only when a final byte waits on a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    frame_stall |-> in_v && in_req.last_byte && result_valid && result_stall)
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

// ----- tb/vcp_brightness_reply_parser_core_tb.sv -----
// Self-checking testbench for vcp_brightness_reply_parser_core: directed and random
// reply frames, a byte-level predictor in a small scoreboard class, random idling.
// Depends on vbrp_pkg and the parser RTL.
`default_nettype none

module vcp_brightness_reply_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vbrp_pkg::*;

  // Field values of a healthy reply that the package does not name.
  localparam logic [7:0] RC_OK           = 8'h00;
  localparam logic [7:0] TYPE_CONTINUOUS = 8'h00;

  // Number of random request bytes after the directed frames.
  localparam int unsigned RandomBytes = 600;

  // Keeps a shadow copy of the parser state, turns each accepted request into
  // the reply verdict it should cause and matches results against those.
  class reply_scoreboard;
    logic [3:0]  seen_count;
    logic [7:0]  running_xor;
    capture_t    captured;
    result_t     pending_replies[$];
    int unsigned errors;
    int unsigned replies_checked;
    int unsigned status_hits[16];

    function new();
      clear_frame();
      errors = 0;
      replies_checked = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void clear_frame();
      seen_count  = '0;
      running_xor = CSUM_SEED;
      captured    = '0;
    endfunction

    // Checks run in priority order; the first failing one decides the status.
    function result_t grade_reply();
      result_t     verdict;
      logic [15:0] top;
      logic [15:0] level;
      top   = {captured[6], captured[7]};
      level = {captured[8], captured[9]};
      verdict.current_level = '0;
      verdict.maximum_level = '0;
      if (seen_count != FrameLen) verdict.status = ST_LENGTH;
      else if (captured[0] != SRC_ADDR) verdict.status = ST_SOURCE;
      else if (captured[1] == NULL_HDR) verdict.status = ST_NULL;
      else if (captured[1] != REPLY_HDR) verdict.status = ST_HEADER;
      else if (running_xor != 8'h00) verdict.status = ST_CHECKSUM;
      else if (captured[2] != GET_REPLY_OP || captured[4] != VCP_BRIGHT)
        verdict.status = ST_NOT_QUERY;
      else if (captured[3] == RC_UNSUPPORTED) verdict.status = ST_UNSUPPORTED;
      else if (captured[3] != RC_OK) verdict.status = ST_UNKNOWN_CODE;
      else if (captured[5] != TYPE_CONTINUOUS) verdict.status = ST_NOT_CONTINUOUS;
      else if (top == 16'h0000 || level > top) verdict.status = ST_INCONSISTENT;
      else begin
        verdict.status        = ST_OK;
        verdict.current_level = level;
        verdict.maximum_level = top;
      end
      return verdict;
    endfunction

    function void note_request(byte_req_t req);
      result_t verdict;
      if (seen_count < CaptureLen) captured[seen_count] = req.data_byte;
      running_xor = running_xor ^ req.data_byte;
      if (seen_count != COUNT_MAX) seen_count = seen_count + 4'd1;
      if (req.last_byte) begin
        verdict = grade_reply();
        pending_replies.push_back(verdict);
        status_hits[verdict.status]++;
        clear_frame();
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, status %0d current %h maximum %h",
                 $time, got.status, got.current_level, got.maximum_level);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      replies_checked++;
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.current_level !== want.current_level) begin
        $display("%0t: current_level expected %h actual %h",
                 $time, want.current_level, got.current_level);
        errors++;
      end
      if (got.maximum_level !== want.maximum_level) begin
        $display("%0t: maximum_level expected %h actual %h",
                 $time, want.maximum_level, got.maximum_level);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_replies.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      frame_valid;
  logic      frame_stall;
  byte_req_t frame_data;
  logic      result_valid;
  logic      result_stall;
  result_t   result_data;

  reply_scoreboard sb = new();

  // Bytes of the frame about to be sent, built by the tasks below.
  logic [7:0]  frame_bytes[$];
  int unsigned bytes_sent;
  int unsigned burst_left;
  int unsigned cycle_count;

  vcp_brightness_reply_parser_core u_top (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame_data   (frame_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver side. Outputs are sampled at the rising edge before any of this
  // edge's updates land, so a result counts as taken exactly when the parser
  // saw valid high and stall low. The stall pattern takes turns among four
  // styles: no stall at all, light and heavy random stalls, and a fixed
  // periodic pattern.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      cycle_count  <= 0;
    end else begin
      if (result_valid && !result_stall) sb.check_result(result_data);
      cycle_count <= cycle_count + 1;
      case ((cycle_count / 300) % 4)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= ($urandom_range(0, 3) != 0);
        default: result_stall <= ((cycle_count % 8) < 5);
      endcase
    end
  end

  // Offers one request and holds it until the parser takes it. Between
  // bursts of random length the sender drops valid for a random gap; some
  // bursts end with no gap so long back-to-back stretches also occur.
  task automatic send_byte(input byte_req_t req);
    int unsigned gap;
    frame_valid <= 1'b1;
    frame_data  <= req;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    sb.note_request(req);
    bytes_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        frame_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Sends the built frame, flagging its final byte.
  task automatic send_frame();
    byte_req_t req;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      req.data_byte = frame_bytes[i];
      req.last_byte = (i == frame_bytes.size() - 1);
      send_byte(req);
    end
  endtask

  // Writes the checksum byte so the XOR of the seed and all eleven bytes is 0.
  task automatic seal_reply();
    logic [7:0] sum;
    sum = CSUM_SEED;
    for (int i = 0; i < 10; i++) sum = sum ^ frame_bytes[i];
    frame_bytes[10] = sum;
  endtask

  task automatic make_reply(input logic [15:0] top, input logic [15:0] level);
    frame_bytes = {SRC_ADDR, REPLY_HDR, GET_REPLY_OP, RC_OK, VCP_BRIGHT, TYPE_CONTINUOUS,
                   top[15:8], top[7:0], level[15:8], level[7:0], 8'h00};
    seal_reply();
  endtask

  // Holds the sender off until every reply owed has come out. Valid is dropped
  // before the wait so the next request starts in a later time step.
  task automatic wait_drained();
    frame_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Well-formed replies with random levels, a slightly larger share with exactly
  // one field broken on purpose, and some pure noise of random length.
  task automatic random_frame();
    status_t     flaw;
    logic [15:0] top;
    logic [15:0] level;
    int unsigned kind;
    int unsigned len;
    kind  = $urandom_range(0, 99);
    top   = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom_range(1, 65535));
    level = ($urandom_range(0, 7) == 0) ? top : 16'($urandom_range(0, top));
    make_reply(top, level);
    if (kind < 15) begin
      len = $urandom_range(1, 20);
      frame_bytes.delete();
      repeat (len) frame_bytes.push_back(8'($urandom));
    end else if (kind >= 55) begin
      flaw = status_t'($urandom_range(ST_LENGTH, ST_INCONSISTENT));
      case (flaw)
        ST_LENGTH: begin
          len = $urandom_range(1, 19);
          if (len >= FrameLen) len++;
          while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
          while (frame_bytes.size() < len) frame_bytes.push_back(8'($urandom));
        end
        ST_SOURCE: frame_bytes[0] = SRC_ADDR ^ 8'($urandom_range(1, 255));
        ST_NULL: frame_bytes[1] = NULL_HDR;
        ST_HEADER: frame_bytes[1] = REPLY_HDR ^ 8'($urandom_range(1, 255));
        ST_NOT_QUERY: begin
          if ($urandom_range(0, 1) == 0) frame_bytes[2] = GET_REPLY_OP ^ 8'($urandom_range(1, 255));
          else frame_bytes[4] = VCP_BRIGHT ^ 8'($urandom_range(1, 255));
        end
        ST_UNSUPPORTED: frame_bytes[3] = RC_UNSUPPORTED;
        ST_UNKNOWN_CODE: frame_bytes[3] = 8'($urandom_range(2, 255));
        ST_NOT_CONTINUOUS: frame_bytes[5] = 8'($urandom_range(1, 255));
        ST_INCONSISTENT: begin
          // Either a zero maximum or a current level above the maximum.
          if (top == 16'hffff || $urandom_range(0, 1) == 0) begin
            frame_bytes[6] = 8'h00;
            frame_bytes[7] = 8'h00;
          end else begin
            level = 16'($urandom_range(top + 1, 65535));
            frame_bytes[8] = level[15:8];
            frame_bytes[9] = level[7:0];
          end
        end
        default: ;
      endcase
      if (flaw != ST_LENGTH) seal_reply();
      if (flaw == ST_CHECKSUM) frame_bytes[10] = frame_bytes[10] ^ 8'($urandom_range(1, 255));
    end
    send_frame();
  endtask

  // Main sequence: reset, directed frames, a full drain, random frames with a
  // second drain halfway, then a final wait and the verdict.
  initial begin
    int unsigned kinds_seen;
    rst          = 1'b1;
    frame_valid  = 1'b0;
    frame_data   = '0;
    result_stall = 1'b0;
    bytes_sent   = 0;
    burst_left   = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Good replies, including the widest and the smallest legal levels.
    make_reply(16'd100, 16'd50);
    send_frame();
    make_reply(16'hffff, 16'hffff);
    send_frame();
    make_reply(16'h0001, 16'h0000);
    send_frame();

    // Length errors: a lone final byte, one short, one long, and a frame
    // long enough to pin the byte count at its ceiling.
    frame_bytes = {8'hff};
    send_frame();
    make_reply(16'd100, 16'd50);
    void'(frame_bytes.pop_back());
    send_frame();
    make_reply(16'd100, 16'd50);
    frame_bytes.push_back(8'h00);
    send_frame();
    make_reply(16'd100, 16'd50);
    repeat (9) frame_bytes.push_back(8'($urandom));
    send_frame();

    // One broken field per frame, resealed but for the checksum one: only it trips.
    make_reply(16'd100, 16'd50);
    frame_bytes[0] = 8'h6f;
    seal_reply();
    send_frame();
    make_reply(16'd100, 16'd50);
    frame_bytes[1] = NULL_HDR;
    seal_reply();
    send_frame();
    make_reply(16'd100, 16'd50);
    frame_bytes[1] = 8'h00;
    seal_reply();
    send_frame();
    make_reply(16'd100, 16'd50);
    frame_bytes[10] = ~frame_bytes[10];
    send_frame();
    make_reply(16'd100, 16'd50);
    frame_bytes[2] = 8'h03;
    seal_reply();
    send_frame();
    make_reply(16'd100, 16'd50);
    frame_bytes[4] = 8'h12;
    seal_reply();
    send_frame();
    make_reply(16'd100, 16'd50);
    frame_bytes[3] = RC_UNSUPPORTED;
    seal_reply();
    send_frame();
    make_reply(16'd100, 16'd50);
    frame_bytes[3] = 8'hff;
    seal_reply();
    send_frame();
    make_reply(16'd100, 16'd50);
    frame_bytes[5] = 8'h01;
    seal_reply();
    send_frame();
    make_reply(16'h0000, 16'h0000);
    send_frame();
    make_reply(16'h0100, 16'h0101);
    send_frame();

    wait_drained();

    begin
      int unsigned random_start;
      random_start = bytes_sent;
      while (bytes_sent < random_start + RandomBytes) begin
        random_frame();
        if (bytes_sent >= random_start + RandomBytes / 2 &&
            bytes_sent < random_start + RandomBytes / 2 + 20) wait_drained();
      end
    end

    // The result register follows the input register; after the final drain
    // the bench keeps running so that any stray output would be seen.
    wait_drained();
    repeat (6) @(posedge clk);

    kinds_seen = 0;
    foreach (sb.status_hits[i]) if (sb.status_hits[i] != 0) kinds_seen++;
    $display("Run sent %0d request bytes and checked %0d replies;", bytes_sent,
             sb.replies_checked);
    $display("%0d distinct status codes were produced, %0d errors found.", kinds_seen,
             sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of about eight hundred bytes.
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

// ----- vcp_brightness_reply_parser_core.f -----
hw/rtl/vbrp_pkg.sv
hw/rtl/vbrp_judge.sv
hw/rtl/vcp_brightness_reply_parser_core.sv
tb/vcp_brightness_reply_parser_core_tb.sv
